[rtl/lox_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lox_pkg: shared types and constants for the Lox scanner
// Item structs, scanner modes, token kinds, character codes and the
// keyword table.
// ----------------------------------------------------------------------------
package lox_pkg;

  localparam int unsigned OFFSET_BITS_DEF = 20;
  localparam int unsigned FIELD_W         = 20;
  localparam int unsigned KIND_W          = 6;
  localparam int unsigned MAX_RES         = 3;
  localparam int unsigned RQ_DEPTH        = 4;
  localparam int unsigned RQ_PTR_W        = 2;
  localparam int unsigned KW_COUNT        = 16;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
  } in_t;

  typedef struct packed {
    logic [KIND_W-1:0]  token_kind;
    logic [FIELD_W-1:0] lexeme_start;
    logic [FIELD_W-1:0] lexeme_length;
    logic [FIELD_W-1:0] line_number;
    logic               unterminated;
    logic               last_of_run;
  } out_t;

  // results produced by one accepted item, in order
  typedef struct packed {
    logic [1:0]       cnt;
    out_t [MAX_RES-1:0] item;
  } res_bundle_t;

  typedef enum logic [3:0] {
    M_IDLE    = 4'd0,
    M_SLASH   = 4'd1,
    M_OP      = 4'd2,
    M_COMMENT = 4'd3,
    M_STRING  = 4'd4,
    M_NUMBER  = 4'd5,
    M_NUMDOT  = 4'd6,
    M_FRAC    = 4'd7,
    M_IDENT   = 4'd8
  } lex_mode_t;

  // pending operator codes
  localparam logic [1:0] PO_BANG = 2'd0;
  localparam logic [1:0] PO_EQ   = 2'd1;
  localparam logic [1:0] PO_GT   = 2'd2;
  localparam logic [1:0] PO_LT   = 2'd3;

  // token kinds
  localparam logic [KIND_W-1:0] K_LPAREN  = 6'd0;
  localparam logic [KIND_W-1:0] K_RPAREN  = 6'd1;
  localparam logic [KIND_W-1:0] K_LBRACE  = 6'd2;
  localparam logic [KIND_W-1:0] K_RBRACE  = 6'd3;
  localparam logic [KIND_W-1:0] K_COMMA   = 6'd4;
  localparam logic [KIND_W-1:0] K_DOT     = 6'd5;
  localparam logic [KIND_W-1:0] K_MINUS   = 6'd6;
  localparam logic [KIND_W-1:0] K_PLUS    = 6'd7;
  localparam logic [KIND_W-1:0] K_SEMI    = 6'd8;
  localparam logic [KIND_W-1:0] K_SLASH   = 6'd9;
  localparam logic [KIND_W-1:0] K_STAR    = 6'd10;
  localparam logic [KIND_W-1:0] K_BANG    = 6'd11;
  localparam logic [KIND_W-1:0] K_BANG_EQ = 6'd12;
  localparam logic [KIND_W-1:0] K_IDENT   = 6'd19;
  localparam logic [KIND_W-1:0] K_STRING  = 6'd20;
  localparam logic [KIND_W-1:0] K_NUMBER  = 6'd21;
  localparam logic [KIND_W-1:0] K_KW0     = 6'd22;
  localparam logic [KIND_W-1:0] K_EOF     = 6'd38;
  localparam logic [KIND_W-1:0] K_ERROR   = 6'd39;

  // character codes
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;

  // keywords, right aligned, last character in the low byte
  localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
    48'("and"),   48'("class"), 48'("else"),   48'("false"),
    48'("fun"),   48'("for"),   48'("if"),     48'("nil"),
    48'("or"),    48'("print"), 48'("return"), 48'("super"),
    48'("this"),  48'("true"),  48'("var"),    48'("while")
  };

  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd3, 3'd5, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd3,
    3'd2, 3'd5, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5
  };

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_alph(input logic [7:0] c);
    return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ)) ||
           (c == CH_UNDER);
  endfunction

  // parallel compare of the last n identifier bytes against all keywords
  function automatic logic [KIND_W-1:0] kw_kind(input logic [2:0] n,
                                                input logic [47:0] kb);
    logic [47:0]       mask;
    logic [KIND_W-1:0] kind;
    mask = ~(48'hFFFF_FFFF_FFFF << {n, 3'b000});
    kind = K_IDENT;
    for (int k = 0; k < KW_COUNT; k++) begin
      if ((n == KW_LEN[k]) && ((kb & mask) == KW_TEXT[k])) begin
        kind = K_KW0 + KIND_W'(k);
      end
    end
    return kind;
  endfunction

endpackage
`default_nettype wire

[rtl/lox_scan.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lox_scan: scanner state and per-byte token logic
// Holds the mode, token start, offset, line count and identifier bytes;
// turns one item into up to three token results in a single pass.
// ----------------------------------------------------------------------------
module lox_scan #(
  parameter int unsigned OFFSET_BITS = lox_pkg::OFFSET_BITS_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  take,
  input  lox_pkg::in_t         in_item,
  output lox_pkg::res_bundle_t res
);

  typedef logic [OFFSET_BITS-1:0] ofs_t;

  lox_pkg::lex_mode_t mode_r, mode_nxt;
  logic [47:0]        kb_r, kb_nxt;
  ofs_t               tb_r, tb_nxt;
  ofs_t               off_r, off_nxt;
  ofs_t               line_r, line_nxt;
  logic [1:0]         po_r, po_nxt;

  logic [7:0] c;
  logic       is_end;
  logic       c_dig, c_alph;
  ofs_t       p, p_inc, dot, line_inc;
  ofs_t       len_id;
  logic [lox_pkg::KIND_W-1:0] kind_id, kind_op;
  logic       do_flush, do_fresh, op_pair, str_close;

  lox_pkg::out_t [lox_pkg::MAX_RES-1:0] items;
  logic [1:0] n;

  function automatic ofs_t span(input ofs_t from, input ofs_t to);
    return (to >= from) ? to - from : '0;
  endfunction

  function automatic lox_pkg::out_t mk(input logic [lox_pkg::KIND_W-1:0] kind,
                                       input ofs_t start, input ofs_t len,
                                       input logic unterm, input ofs_t line);
    lox_pkg::out_t o;
    o.token_kind    = kind;
    o.lexeme_start  = lox_pkg::FIELD_W'(start);
    o.lexeme_length = lox_pkg::FIELD_W'(len);
    o.line_number   = lox_pkg::FIELD_W'(line);
    o.unterminated  = unterm;
    o.last_of_run   = 1'b0;
    return o;
  endfunction

  assign c        = in_item.ch;
  assign is_end   = in_item.is_end;
  assign c_dig    = lox_pkg::is_dig(c);
  assign c_alph   = lox_pkg::is_alph(c);
  assign p        = off_r;
  assign p_inc    = (&p) ? p : p + 1'b1;
  assign dot      = (p != '0) ? p - 1'b1 : '0;
  assign line_inc = (&line_r) ? line_r : line_r + 1'b1;
  assign len_id   = span(tb_r, p);
  assign kind_id  = ((len_id >> 3) == '0) ? lox_pkg::kw_kind(len_id[2:0], kb_r)
                                          : lox_pkg::K_IDENT;
  assign kind_op  = lox_pkg::K_BANG + lox_pkg::KIND_W'({po_r, 1'b0});

  // what the byte does to the current token
  always_comb begin
    do_flush  = 1'b0;
    do_fresh  = 1'b0;
    op_pair   = 1'b0;
    str_close = 1'b0;
    if (is_end) begin
      do_flush = 1'b1;
    end else begin
      case (mode_r)
        lox_pkg::M_SLASH: begin
          if (c != lox_pkg::CH_SLASH) begin
            do_flush = 1'b1;
            do_fresh = 1'b1;
          end
        end
        lox_pkg::M_OP: begin
          if (c == lox_pkg::CH_EQ) begin
            op_pair = 1'b1;
          end else begin
            do_flush = 1'b1;
            do_fresh = 1'b1;
          end
        end
        lox_pkg::M_COMMENT: begin
          do_fresh = (c == lox_pkg::CH_LF);
        end
        lox_pkg::M_STRING: begin
          str_close = (c == lox_pkg::CH_QUOTE);
        end
        lox_pkg::M_NUMBER: begin
          if ((c != lox_pkg::CH_DOT) && !c_dig) begin
            do_flush = 1'b1;
            do_fresh = 1'b1;
          end
        end
        lox_pkg::M_NUMDOT, lox_pkg::M_FRAC: begin
          if (!c_dig) begin
            do_flush = 1'b1;
            do_fresh = 1'b1;
          end
        end
        lox_pkg::M_IDENT: begin
          if (!(c_alph || c_dig)) begin
            do_flush = 1'b1;
            do_fresh = 1'b1;
          end
        end
        default: begin
          do_fresh = 1'b1;
        end
      endcase
    end
  end

  // next state
  always_comb begin
    mode_nxt = mode_r;
    kb_nxt   = kb_r;
    tb_nxt   = tb_r;
    off_nxt  = off_r;
    line_nxt = line_r;
    po_nxt   = po_r;
    if (is_end) begin
      mode_nxt = lox_pkg::M_IDLE;
      tb_nxt   = p;
    end else begin
      off_nxt = p_inc;
      if (do_flush || op_pair || str_close) begin
        mode_nxt = lox_pkg::M_IDLE;
      end
      case (mode_r)
        lox_pkg::M_SLASH: begin
          if (c == lox_pkg::CH_SLASH) begin
            mode_nxt = lox_pkg::M_COMMENT;
          end
        end
        lox_pkg::M_STRING: begin
          if (c == lox_pkg::CH_LF) begin
            line_nxt = line_inc;
          end
        end
        lox_pkg::M_NUMBER: begin
          if (c == lox_pkg::CH_DOT) begin
            mode_nxt = lox_pkg::M_NUMDOT;
          end
        end
        lox_pkg::M_NUMDOT: begin
          if (c_dig) begin
            mode_nxt = lox_pkg::M_FRAC;
          end
        end
        lox_pkg::M_IDENT: begin
          if (c_alph || c_dig) begin
            kb_nxt = {kb_r[39:0], c};
          end
        end
        default: begin
        end
      endcase
      if (do_fresh) begin
        tb_nxt   = p;
        mode_nxt = lox_pkg::M_IDLE;
        case (c)
          lox_pkg::CH_BANG: begin
            po_nxt   = lox_pkg::PO_BANG;
            mode_nxt = lox_pkg::M_OP;
          end
          lox_pkg::CH_EQ: begin
            po_nxt   = lox_pkg::PO_EQ;
            mode_nxt = lox_pkg::M_OP;
          end
          lox_pkg::CH_GT: begin
            po_nxt   = lox_pkg::PO_GT;
            mode_nxt = lox_pkg::M_OP;
          end
          lox_pkg::CH_LT: begin
            po_nxt   = lox_pkg::PO_LT;
            mode_nxt = lox_pkg::M_OP;
          end
          lox_pkg::CH_SLASH: begin
            mode_nxt = lox_pkg::M_SLASH;
          end
          lox_pkg::CH_LF: begin
            line_nxt = line_inc;
          end
          lox_pkg::CH_QUOTE: begin
            mode_nxt = lox_pkg::M_STRING;
          end
          default: begin
            if (c_dig) begin
              mode_nxt = lox_pkg::M_NUMBER;
            end else if (c_alph) begin
              kb_nxt   = {40'b0, c};
              mode_nxt = lox_pkg::M_IDENT;
            end
          end
        endcase
      end
    end
  end

  // results, in emission order: flushed token(s), then the new byte or EOF
  always_comb begin
    items = '0;
    n     = 2'd0;
    if (do_flush) begin
      case (mode_r)
        lox_pkg::M_SLASH: begin
          items[n] = mk(lox_pkg::K_SLASH, tb_r, ofs_t'(1), 1'b0, line_r);
          n = n + 2'd1;
        end
        lox_pkg::M_OP: begin
          items[n] = mk(kind_op, tb_r, ofs_t'(1), 1'b0, line_r);
          n = n + 2'd1;
        end
        lox_pkg::M_STRING: begin
          items[n] = mk(lox_pkg::K_STRING, tb_r, span(tb_r, p), 1'b1, line_r);
          n = n + 2'd1;
        end
        lox_pkg::M_NUMBER, lox_pkg::M_FRAC: begin
          items[n] = mk(lox_pkg::K_NUMBER, tb_r, span(tb_r, p), 1'b0, line_r);
          n = n + 2'd1;
        end
        lox_pkg::M_NUMDOT: begin
          // the dot was not followed by a digit: number, then a lone dot
          items[n] = mk(lox_pkg::K_NUMBER, tb_r, span(tb_r, dot), 1'b0, line_r);
          n = n + 2'd1;
          items[n] = mk(lox_pkg::K_DOT, dot, ofs_t'(1), 1'b0, line_r);
          n = n + 2'd1;
        end
        lox_pkg::M_IDENT: begin
          items[n] = mk(kind_id, tb_r, len_id, 1'b0, line_r);
          n = n + 2'd1;
        end
        default: begin
        end
      endcase
    end
    if (is_end) begin
      items[n] = mk(lox_pkg::K_EOF, p, ofs_t'(0), 1'b0, line_r);
      n = n + 2'd1;
    end else if (op_pair) begin
      items[n] = mk(lox_pkg::K_BANG_EQ + lox_pkg::KIND_W'({po_r, 1'b0}), tb_r,
                    ofs_t'(2), 1'b0, line_r);
      n = n + 2'd1;
    end else if (str_close) begin
      items[n] = mk(lox_pkg::K_STRING, tb_r, span(tb_r, p_inc), 1'b0, line_r);
      n = n + 2'd1;
    end else if (do_fresh) begin
      case (c)
        lox_pkg::CH_LPAREN: begin
          items[n] = mk(lox_pkg::K_LPAREN, p, ofs_t'(1), 1'b0, line_r);
          n = n + 2'd1;
        end
        lox_pkg::CH_RPAREN: begin
          items[n] = mk(lox_pkg::K_RPAREN, p, ofs_t'(1), 1'b0, line_r);
          n = n + 2'd1;
        end
        lox_pkg::CH_LBRACE: begin
          items[n] = mk(lox_pkg::K_LBRACE, p, ofs_t'(1), 1'b0, line_r);
          n = n + 2'd1;
        end
        lox_pkg::CH_RBRACE: begin
          items[n] = mk(lox_pkg::K_RBRACE, p, ofs_t'(1), 1'b0, line_r);
          n = n + 2'd1;
        end
        lox_pkg::CH_COMMA: begin
          items[n] = mk(lox_pkg::K_COMMA, p, ofs_t'(1), 1'b0, line_r);
          n = n + 2'd1;
        end
        lox_pkg::CH_DOT: begin
          items[n] = mk(lox_pkg::K_DOT, p, ofs_t'(1), 1'b0, line_r);
          n = n + 2'd1;
        end
        lox_pkg::CH_MINUS: begin
          items[n] = mk(lox_pkg::K_MINUS, p, ofs_t'(1), 1'b0, line_r);
          n = n + 2'd1;
        end
        lox_pkg::CH_PLUS: begin
          items[n] = mk(lox_pkg::K_PLUS, p, ofs_t'(1), 1'b0, line_r);
          n = n + 2'd1;
        end
        lox_pkg::CH_SEMI: begin
          items[n] = mk(lox_pkg::K_SEMI, p, ofs_t'(1), 1'b0, line_r);
          n = n + 2'd1;
        end
        lox_pkg::CH_STAR: begin
          items[n] = mk(lox_pkg::K_STAR, p, ofs_t'(1), 1'b0, line_r);
          n = n + 2'd1;
        end
        lox_pkg::CH_BANG, lox_pkg::CH_EQ, lox_pkg::CH_GT, lox_pkg::CH_LT,
        lox_pkg::CH_SLASH, lox_pkg::CH_SPACE, lox_pkg::CH_TAB, lox_pkg::CH_CR,
        lox_pkg::CH_LF, lox_pkg::CH_QUOTE: begin
          n = n;
        end
        default: begin
          if (!c_dig && !c_alph) begin
            items[n] = mk(lox_pkg::K_ERROR, p, ofs_t'(1), 1'b0, line_r);
            n = n + 2'd1;
          end
        end
      endcase
    end
    if (n != 2'd0) begin
      items[n - 2'd1].last_of_run = 1'b1;
    end
  end

  assign res.cnt  = take ? n : 2'd0;
  assign res.item = items;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= lox_pkg::M_IDLE;
      kb_r   <= '0;
      tb_r   <= '0;
      off_r  <= '0;
      line_r <= ofs_t'(1);
      po_r   <= lox_pkg::PO_BANG;
    end else if (take) begin
      mode_r <= mode_nxt;
      kb_r   <= kb_nxt;
      tb_r   <= tb_nxt;
      off_r  <= off_nxt;
      line_r <= line_nxt;
      po_r   <= po_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/lox_resq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lox_resq: result queue
// Four-entry ring that takes up to three results per cycle and hands out
// one per cycle on the result channel while out_ready is high.
// ----------------------------------------------------------------------------
module lox_resq (
  input  wire                  clk,
  input  wire                  rst_n,
  input  lox_pkg::res_bundle_t push,
  input  wire                  out_ready,
  output logic                 out_valid,
  output lox_pkg::out_t        out_data,
  output logic                 room
);

  localparam int unsigned PW = lox_pkg::RQ_PTR_W;
  localparam int unsigned CW = $clog2(lox_pkg::RQ_DEPTH + 1);

  lox_pkg::out_t  mem [lox_pkg::RQ_DEPTH];
  logic [PW-1:0]  wr_r, wr_nxt;
  logic [PW-1:0]  rd_r, rd_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem[rd_r];
  assign pop       = out_valid && out_ready;
  // room for a worst-case item, counted before this cycle's pop
  assign room      = (cnt_r <= CW'(lox_pkg::RQ_DEPTH - lox_pkg::MAX_RES));

  always_comb begin
    wr_nxt  = wr_r + PW'(push.cnt);
    rd_nxt  = rd_r + PW'(pop);
    cnt_nxt = cnt_r + CW'(push.cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < lox_pkg::MAX_RES; i++) begin
      if (2'(i) < push.cnt) begin
        mem[wr_r + PW'(i)] <= push.item[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/lox_lexer.sv]
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one byte per cycle while each byte yields at most one token
// and out_ready is high; a byte that yields two or three tokens holds
// in_ready low until the four-entry result queue drains to one entry or
// fewer (one token leaves per cycle while out_ready is high).
// Reset: synchronous, active low; mode idle, offset 0, line 1, queue empty.
// ----------------------------------------------------------------------------
// lox_lexer: streaming Lox scanner
// Takes source bytes and an end marker, emits tokens with kind, start,
// length and line number.
// ----------------------------------------------------------------------------
module lox_lexer #(
  parameter int unsigned OFFSET_BITS = lox_pkg::OFFSET_BITS_DEF
) (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           in_valid,
  output logic          in_ready,
  input  lox_pkg::in_t  in_data,
  output logic          out_valid,
  input  wire           out_ready,
  output lox_pkg::out_t out_data
);

  lox_pkg::res_bundle_t res;
  logic                 take;
  logic                 room;

  assign in_ready = room;
  assign take     = in_valid && room;

  lox_scan #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (take),
    .in_item(in_data),
    .res    (res)
  );

  lox_resq u_resq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_data (out_data),
    .room     (room)
  );

endmodule
`default_nettype wire
